/* hw/rtl/srb_pkg.sv */
package srb_pkg;

   localparam int SEQ_W          = 32;
   localparam int DESC_W         = 32;
   localparam int KIND_W         = 2;
   localparam int ERR_W          = 3;
   localparam int WINDOW_DEFAULT = 16;

   localparam logic FUNC_ITEM = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_RELEASE = 2'd0,
      KIND_FINISH  = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 3'd0,
      ERR_STALE   = 3'd1,
      ERR_DUP     = 3'd2,
      ERR_MISSING = 3'd3,
      ERR_BEYOND  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_READ,
      ST_OUT
   } state_type;

endpackage

/* hw/rtl/srb_if.sv */
interface srb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [srb_pkg::SEQ_W-1:0]  seq_index;
   logic [srb_pkg::DESC_W-1:0] payload_desc;
   logic                      upstream_failed;

   modport source (output valid, func, seq_index, payload_desc, upstream_failed,
                   input ready);
   modport sink (input valid, func, seq_index, payload_desc, upstream_failed,
                 output ready);
endinterface

interface srb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [srb_pkg::KIND_W-1:0] out_kind;
   logic [srb_pkg::SEQ_W-1:0]  out_index;
   logic [srb_pkg::DESC_W-1:0] out_payload;
   logic [srb_pkg::ERR_W-1:0]  error_code;
   logic                      run_last;

   modport source (output valid, out_kind, out_index, out_payload, error_code,
                   run_last, input ready);
   modport sink (input valid, out_kind, out_index, out_payload, error_code,
                 run_last, output ready);
endinterface

/* hw/rtl/srb_slot_mem.sv */
module srb_slot_mem #(
   parameter int DEPTH = srb_pkg::WINDOW_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [srb_pkg::DESC_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [srb_pkg::DESC_W-1:0] rd_data
);

   logic [srb_pkg::DESC_W-1:0] mem_ff [DEPTH];
   logic [srb_pkg::DESC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/srb_ctrl.sv */
module srb_ctrl #(
   parameter int WINDOW = srb_pkg::WINDOW_DEFAULT,
   localparam int IW    = $clog2(WINDOW)
) (
   input  logic                       clock,
   input  logic                       reset,
   srb_req_if.sink                    req_ch,
   srb_rsp_if.source                  rsp_ch,
   output logic                       mem_wr_en,
   output logic [IW-1:0]              mem_wr_addr,
   output logic [srb_pkg::DESC_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [IW-1:0]              mem_rd_addr,
   input  logic [srb_pkg::DESC_W-1:0] mem_rd_data
);

   localparam logic [IW:0]               WIN      = (IW+1)'(WINDOW);
   localparam logic [IW-1:0]             HEAD_TOP = IW'(WINDOW - 1);
   localparam logic [srb_pkg::SEQ_W-1:0] WIN_SEQ  = srb_pkg::SEQ_W'(WINDOW);

   srb_pkg::state_type          state_ff, state_in;
   logic [srb_pkg::SEQ_W-1:0]   next_exp_ff, next_exp_in;
   logic [IW-1:0]               head_ff, head_in;
   logic [WINDOW-1:0]           valid_ff, valid_in;
   logic                        failed_ff, failed_in;

   srb_pkg::kind_type           pend_kind_ff, pend_kind_in;
   logic [srb_pkg::SEQ_W-1:0]   pend_index_ff, pend_index_in;
   srb_pkg::err_type            pend_err_ff, pend_err_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   srb_pkg::kind_type           out_kind_ff, out_kind_in;
   logic [srb_pkg::SEQ_W-1:0]   out_index_ff, out_index_in;
   logic [srb_pkg::DESC_W-1:0]  out_payload_ff, out_payload_in;
   srb_pkg::err_type            out_err_ff, out_err_in;
   logic                        run_last_ff, run_last_in;

   logic                        accept;
   logic                        out_free;
   logic                        stale;
   logic                        beyond;
   logic [srb_pkg::SEQ_W-1:0]   offset;
   logic [IW:0]                 slot_sum;
   logic [IW-1:0]               slot;
   logic [IW-1:0]               head_p1;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign stale    = req_ch.seq_index < next_exp_ff;
   assign offset   = req_ch.seq_index - next_exp_ff;
   assign beyond   = offset >= WIN_SEQ;
   // slot is head plus offset, wrapped once around the window
   assign slot_sum = {1'b0, head_ff} + {1'b0, offset[IW-1:0]};
   assign slot     = (slot_sum >= WIN) ? IW'(slot_sum - WIN) : slot_sum[IW-1:0];
   assign head_p1  = (head_ff == HEAD_TOP) ? '0 : head_ff + IW'(1);

   always_comb begin
      state_in       = state_ff;
      next_exp_in    = next_exp_ff;
      head_in        = head_ff;
      valid_in       = valid_ff;
      failed_in      = failed_ff;
      pend_kind_in   = pend_kind_ff;
      pend_index_in  = pend_index_ff;
      pend_err_in    = pend_err_ff;
      out_kind_in    = out_kind_ff;
      out_index_in   = out_index_ff;
      out_payload_in = out_payload_ff;
      out_err_in     = out_err_ff;
      run_last_in    = run_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = slot;
      mem_wr_data    = req_ch.payload_desc;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff;
      req_ch.ready   = (state_ff == srb_pkg::ST_IDLE);

      case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.func == srb_pkg::FUNC_END) begin
                  if (!failed_ff && !req_ch.upstream_failed) begin
                     if (|valid_ff) begin
                        pend_kind_in  = srb_pkg::KIND_ERROR;
                        pend_index_in = next_exp_ff;
                        pend_err_in   = srb_pkg::ERR_MISSING;
                     end else begin
                        pend_kind_in  = srb_pkg::KIND_FINISH;
                        pend_index_in = '0;
                        pend_err_in   = srb_pkg::ERR_NONE;
                     end
                     state_in = srb_pkg::ST_SEND;
                  end
                  // end of stream returns the window state to reset
                  next_exp_in = '0;
                  head_in     = '0;
                  valid_in    = '0;
                  failed_in   = 1'b0;
               end else if (!failed_ff) begin
                  pend_kind_in  = srb_pkg::KIND_ERROR;
                  pend_index_in = req_ch.seq_index;
                  if (stale) begin
                     pend_err_in = srb_pkg::ERR_STALE;
                     failed_in   = 1'b1;
                     state_in    = srb_pkg::ST_SEND;
                  end else if (beyond) begin
                     pend_err_in = srb_pkg::ERR_BEYOND;
                     failed_in   = 1'b1;
                     state_in    = srb_pkg::ST_SEND;
                  end else if (valid_ff[slot]) begin
                     pend_err_in = srb_pkg::ERR_DUP;
                     failed_in   = 1'b1;
                     state_in    = srb_pkg::ST_SEND;
                  end else begin
                     mem_wr_en      = 1'b1;
                     valid_in[slot] = 1'b1;
                     // only an arrival at the head can start a run
                     if (slot == head_ff) begin
                        state_in = srb_pkg::ST_READ;
                     end
                  end
               end
            end
         end
         srb_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_kind_in    = pend_kind_ff;
               out_index_in   = pend_index_ff;
               out_payload_in = '0;
               out_err_in     = pend_err_ff;
               run_last_in    = 1'b1;
               state_in       = srb_pkg::ST_IDLE;
            end
         end
         srb_pkg::ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = srb_pkg::ST_OUT;
         end
         srb_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               out_kind_in       = srb_pkg::KIND_RELEASE;
               out_index_in      = next_exp_ff;
               out_payload_in    = mem_rd_data;
               out_err_in        = srb_pkg::ERR_NONE;
               run_last_in       = !valid_ff[head_p1];
               valid_in[head_ff] = 1'b0;
               next_exp_in       = next_exp_ff + 1'b1;
               head_in           = head_p1;
               // fetch the next held entry while this item goes out
               if (valid_ff[head_p1]) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = head_p1;
               end else begin
                  state_in = srb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srb_pkg::ST_IDLE;
         next_exp_ff  <= '0;
         head_ff      <= '0;
         valid_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_exp_ff  <= next_exp_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff   <= pend_kind_in;
      pend_index_ff  <= pend_index_in;
      pend_err_ff    <= pend_err_in;
      out_kind_ff    <= out_kind_in;
      out_index_ff   <= out_index_in;
      out_payload_ff <= out_payload_in;
      out_err_ff     <= out_err_in;
      run_last_ff    <= run_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_kind    = out_kind_ff;
   assign rsp_ch.out_index   = out_index_ff;
   assign rsp_ch.out_payload = out_payload_ff;
   assign rsp_ch.error_code  = out_err_ff;
   assign rsp_ch.run_last    = run_last_ff;

endmodule

/* hw/rtl/sequence_reorder_buffer.sv */
// Reorder buffer that takes completed items in any order and releases them strictly by
// sequence index through a registered output. An arriving item whose index is not the
// next one expected is written to the slot memory and gives no result. An item that
// fills the head slot starts a run: the READ state issues the first slot memory read,
// then the OUT state releases one item per cycle while the output side does not stall
// (the next read overlaps the current release). The slot memory read is registered.
// Stale, duplicate and out-of-window indexes give one error report, after which arrivals
// are dropped until end of stream; end of stream gives finish or missing-entries unless
// an error was reported or upstream_failed is set, clears all state in the cycle it is
// taken, and posts its result through the SEND state.
module sequence_reorder_buffer #(
   parameter int WINDOW = srb_pkg::WINDOW_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   srb_req_if.sink   req_ch,
   srb_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(WINDOW);

   logic                       mem_wr_en;
   logic [IW-1:0]              mem_wr_addr;
   logic [srb_pkg::DESC_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [IW-1:0]              mem_rd_addr;
   logic [srb_pkg::DESC_W-1:0] mem_rd_data;

   srb_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   srb_slot_mem #(
      .DEPTH (WINDOW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTH
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("slot memory written and read in the same cycle");

   a_write_on_accept : assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (req_ch.valid && req_ch.ready))
      else $error("slot write without an accepted item");

   a_end_no_read : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.func == srb_pkg::FUNC_END) |=> !mem_rd_en)
      else $error("slot read after end of stream");

   a_single_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_kind != srb_pkg::KIND_RELEASE) |-> rsp_ch.run_last)
      else $error("finish or error report not marked last");
`endif

endmodule

/* test/srb_release_monitor.sv */
`timescale 1ns / 1ps

module srb_release_monitor #(
   parameter int WINDOW = srb_pkg::WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   srb_req_if   req_ch,
   srb_rsp_if   rsp_ch,
   output int   error_count,
   output int   due_count
);

   typedef struct {
      srb_pkg::kind_type          kind;
      logic [srb_pkg::SEQ_W-1:0]  index;
      logic [srb_pkg::DESC_W-1:0] payload;
      srb_pkg::err_type           code;
      logic                       last;
   } rsp_item_type;

   rsp_item_type release_due [$];

   logic [srb_pkg::SEQ_W-1:0]  next_seq;
   logic [WINDOW-1:0]          held;
   logic [srb_pkg::DESC_W-1:0] held_desc [WINDOW];
   logic                       halted;
   int                         head;
   int                         mismatches = 0;

   function automatic void clear_window();
      next_seq = '0;
      held     = '0;
      halted   = 1'b0;
      head     = 0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < 60)
         $display("%0t: %s mismatch, want %0h got %0h", $time, what, want, got);
      mismatches++;
   endtask

   task automatic push_error(input logic [srb_pkg::SEQ_W-1:0] index,
                             input srb_pkg::err_type code);
      rsp_item_type r;
      r.kind    = srb_pkg::KIND_ERROR;
      r.index   = index;
      r.payload = '0;
      r.code    = code;
      r.last    = 1'b1;
      release_due.push_back(r);
      halted = 1'b1;
   endtask

   // Work out what one accepted request releases, in order.
   task automatic order_item(input logic func, input logic [srb_pkg::SEQ_W-1:0] seq,
                             input logic [srb_pkg::DESC_W-1:0] desc, input logic upf);
      rsp_item_type              r;
      logic [srb_pkg::SEQ_W-1:0] offset;
      int                        slot;
      int                        n;
      if (func == srb_pkg::FUNC_END) begin
         if (!halted && !upf) begin
            r.payload = '0;
            r.last    = 1'b1;
            if (|held) begin
               r.kind  = srb_pkg::KIND_ERROR;
               r.index = next_seq;
               r.code  = srb_pkg::ERR_MISSING;
            end else begin
               r.kind  = srb_pkg::KIND_FINISH;
               r.index = '0;
               r.code  = srb_pkg::ERR_NONE;
            end
            release_due.push_back(r);
         end
         clear_window();
      end else if (!halted) begin
         offset = seq - next_seq;
         if (seq < next_seq) begin
            push_error(seq, srb_pkg::ERR_STALE);
         end else if (offset >= WINDOW) begin
            push_error(seq, srb_pkg::ERR_BEYOND);
         end else begin
            slot = (head + int'(offset)) % WINDOW;
            if (held[slot]) begin
               push_error(seq, srb_pkg::ERR_DUP);
            end else begin
               held[slot]      = 1'b1;
               held_desc[slot] = desc;
               n = 0;
               // drain the run of consecutive held entries from the head
               while (n < WINDOW && held[head]) begin
                  r.kind     = srb_pkg::KIND_RELEASE;
                  r.index    = next_seq;
                  r.payload  = held_desc[head];
                  r.code     = srb_pkg::ERR_NONE;
                  held[head] = 1'b0;
                  next_seq   = next_seq + 1'b1;
                  head       = (head + 1) % WINDOW;
                  n++;
                  r.last     = !held[head] || n == WINDOW;
                  release_due.push_back(r);
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type due;
      if (reset) begin
         clear_window();
         release_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (release_due.size() == 0) begin
               report_mismatch("result with nothing due", '0, rsp_ch.out_index);
            end else begin
               due = release_due.pop_front();
               if (rsp_ch.out_kind !== due.kind)
                  report_mismatch("out_kind", 32'(due.kind), 32'(rsp_ch.out_kind));
               if (rsp_ch.out_index !== due.index)
                  report_mismatch("out_index", due.index, rsp_ch.out_index);
               if (rsp_ch.out_payload !== due.payload)
                  report_mismatch("out_payload", due.payload, rsp_ch.out_payload);
               if (rsp_ch.error_code !== due.code)
                  report_mismatch("error_code", 32'(due.code), 32'(rsp_ch.error_code));
               if (rsp_ch.run_last !== due.last)
                  report_mismatch("run_last", 32'(due.last), 32'(rsp_ch.run_last));
            end
         end
         if (req_ch.valid && req_ch.ready)
            order_item(req_ch.func, req_ch.seq_index, req_ch.payload_desc,
                       req_ch.upstream_failed);
      end
      due_count   <= release_due.size();
      error_count <= mismatches;
   end

endmodule

/* test/tb_sequence_reorder_buffer.sv */
`timescale 1ns / 1ps

module tb_sequence_reorder_buffer;

   localparam int WINDOW       = srb_pkg::WINDOW_DEFAULT;
   localparam int RANDOM_ITEMS = 420;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 40;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   due_count;
   int   cycles = 0;
   int   sent = 0;
   int   burst_left = 0;
   int   stretch_left = 0;
   int   ready_odds = 8;

   srb_req_if req_ch ();
   srb_rsp_if rsp_ch ();

   sequence_reorder_buffer #(.WINDOW(WINDOW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   srb_release_monitor #(.WINDOW(WINDOW)) release_mon (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (error_count),
      .due_count   (due_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: stall with a fixed odds of ready over stretches of random length.
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stretch_left <= $urandom_range(8, 96);
         case ($urandom_range(0, 3))
            0: ready_odds <= 8;
            1: ready_odds <= 6;
            2: ready_odds <= 3;
            default: ready_odds <= 1;
         endcase
      end else begin
         stretch_left <= stretch_left - 1;
      end
      rsp_ch.ready <= ($urandom_range(0, 7) < ready_odds);
   end

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_req(input logic func, input logic [srb_pkg::SEQ_W-1:0] seq,
                           input logic [srb_pkg::DESC_W-1:0] desc, input logic upf);
      req_ch.valid           <= 1'b1;
      req_ch.func            <= func;
      req_ch.seq_index       <= seq;
      req_ch.payload_desc    <= desc;
      req_ch.upstream_failed <= upf;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      pace();
   endtask

   task automatic send_end(input logic upf);
      send_req(srb_pkg::FUNC_END, $urandom, $urandom, upf);
   endtask

   // One stream from index zero: out-of-order chunks that fit the window,
   // sometimes broken by a flaw, always closed by end of stream.
   task automatic run_stream();
      int               len, pos, c, j, k, tmp, break_at, extra;
      int               order [WINDOW];
      srb_pkg::err_type flaw;
      logic             broken;
      len      = $urandom_range(1, 48);
      break_at = $urandom_range(0, len - 1);
      broken   = 1'b0;
      case ($urandom_range(0, 9))
         0: flaw = srb_pkg::ERR_STALE;
         1: flaw = srb_pkg::ERR_DUP;
         2: flaw = srb_pkg::ERR_BEYOND;
         3: flaw = srb_pkg::ERR_MISSING;
         default: flaw = srb_pkg::ERR_NONE;
      endcase
      pos = 0;
      while (pos < len && !broken) begin
         c = $urandom_range(1, WINDOW);
         if (c > len - pos) c = len - pos;
         if (pos >= break_at && flaw != srb_pkg::ERR_NONE && flaw != srb_pkg::ERR_MISSING)
         begin
            broken = 1'b1;
            case (flaw)
               srb_pkg::ERR_STALE: begin
                  if (pos > 0)
                     send_req(srb_pkg::FUNC_ITEM, $urandom_range(0, pos - 1), $urandom,
                              1'b0);
                  else
                     send_req(srb_pkg::FUNC_ITEM, WINDOW + $urandom_range(0, 3), $urandom,
                              1'b0);
               end
               srb_pkg::ERR_DUP: begin
                  k = $urandom_range(1, WINDOW - 1);
                  send_req(srb_pkg::FUNC_ITEM, pos + k, $urandom, 1'b0);
                  send_req(srb_pkg::FUNC_ITEM, pos + k, $urandom, 1'b0);
               end
               default: begin
                  if ($urandom_range(0, 1) == 0)
                     send_req(srb_pkg::FUNC_ITEM, pos + WINDOW + $urandom_range(0, 7),
                              $urandom, 1'b0);
                  else
                     send_req(srb_pkg::FUNC_ITEM, $urandom, $urandom,
                              1'($urandom_range(0, 1)));
               end
            endcase
            // these follow the error and are dropped
            extra = $urandom_range(0, 3);
            repeat (extra) begin
               send_req(srb_pkg::FUNC_ITEM, $urandom_range(0, 2 * WINDOW), $urandom, 1'b0);
               sent--;
            end
         end else begin
            for (j = 0; j < c; j++) order[j] = pos + j;
            for (j = c - 1; j > 0; j--) begin
               k = $urandom_range(0, j);
               tmp = order[j];
               order[j] = order[k];
               order[k] = tmp;
            end
            for (j = 0; j < c; j++) begin
               // hold back one index of the final chunk to leave a hole
               if (!(flaw == srb_pkg::ERR_MISSING && pos + c == len && j == 0))
                  send_req(srb_pkg::FUNC_ITEM, order[j], $urandom,
                           1'($urandom_range(0, 1)));
            end
            pos += c;
         end
      end
      send_end($urandom_range(0, 7) == 0);
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) send_req(1'($urandom_range(0, 1)), $urandom, $urandom,
                          1'($urandom_range(0, 1)));
      send_end($urandom_range(0, 3) == 0);
   endtask

   initial begin
      int k;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.func            = srb_pkg::FUNC_ITEM;
      req_ch.seq_index       = '0;
      req_ch.payload_desc    = '0;
      req_ch.upstream_failed = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full window filled from the top down, then the head releases all of it
      for (k = WINDOW - 1; k >= 0; k--)
         send_req(srb_pkg::FUNC_ITEM, k, (k == WINDOW - 1) ? 32'hFFFF_FFFF :
                  (k == 0) ? 32'h0 : $urandom, k[0]);
      send_req(srb_pkg::FUNC_ITEM, WINDOW - 1, $urandom, 1'b0);    // stale
      send_req(srb_pkg::FUNC_ITEM, WINDOW + 4, $urandom, 1'b0);    // dropped after error
      send_end(1'b0);                                              // silent after error
      send_req(srb_pkg::FUNC_ITEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // beyond window
      send_end(1'b1);
      send_req(srb_pkg::FUNC_ITEM, 2, 32'h5A5A_A5A5, 1'b0);        // held, nothing ready
      send_end(1'b0);                                              // missing at end
      send_end(1'b0);                                              // finish
      send_req(srb_pkg::FUNC_ITEM, 1, $urandom, 1'b0);
      send_req(srb_pkg::FUNC_ITEM, 1, $urandom, 1'b0);             // duplicate
      send_end(1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 11) == 0) run_noise();
         else run_stream();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && due_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
